### rtl/fdrs_pkg.sv
// shared types, command codes and mask constants for the flip-dot refresh scanner
// no dependencies; used by fdrs_scan_seq and flip_dot_refresh_scanner_core
package fdrs_pkg;

	typedef enum logic [2:0] {
		CMD_WRITE   = 3'd0,
		CMD_READ    = 3'd1,
		CMD_REFRESH = 3'd2,
		CMD_FORCE   = 3'd3,
		CMD_STEP    = 3'd4
	} fdrs_cmd_t;

	localparam logic [1:0] REG_RELATIVE = 2'd0;
	localparam logic [1:0] REG_POLARITY = 2'd1;
	localparam logic [1:0] REG_PANELS   = 2'd2;

	localparam logic [7:0] MASK_EVEN = 8'hAA;
	localparam logic [7:0] MASK_ODD  = 8'h55;
	localparam logic [7:0] PIX_MSB   = 8'h80;

	typedef struct packed {
		logic [2:0] command;
		logic [3:0] byte_col;
		logic [2:0] row_index;
		logic [7:0] byte_data;
	} fdrs_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       pulse_fire;
		logic       pulse_set;
		logic [2:0] pulse_row;
		logic [6:0] pulse_col;
		logic       scan_busy;
		logic       scan_done;
		logic       rejected;
	} fdrs_rsp_t;

	// requests from the datapath to the scan sequencer
	typedef struct packed {
		logic start;
		logic force_scan;
		logic step;
	} fdrs_scan_cmd_t;

	// sequencer status seen by the datapath
	typedef struct packed {
		logic busy;
		logic forcing;
		logic phase;
		logic last;
	} fdrs_scan_sts_t;

	// checkerboard mask by row parity and polarity
	function automatic logic [7:0] row_mask(input logic row_lsb, input logic polarity);
		return (row_lsb ^ polarity) ? MASK_ODD : MASK_EVEN;
	endfunction

endpackage

### rtl/flip_dot_refresh_scanner_core.sv
// flip-dot frame buffer with refresh scanner: access and scan datapath
// depends on fdrs_pkg, fdrs_ram, fdrs_scan_seq
// request path: a request beat issues the ram read and registers the request; the result is
//   then computed from the ram data into the result register
// flow: one request in flight, read then write back through the frame and previous-frame
//   memories; no new request is taken while one computes or while the result waits untaken
// reset: registers return to relative mode, polarity 0, four panels, scan idle; both
//   memories read as zero through per-entry valid flags, no clearing pass
module flip_dot_refresh_scanner_core #(
	parameter int ROWS           = 8,
	parameter int COLS_PER_PANEL = 32,
	parameter int MAX_PANELS     = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  fdrs_pkg::fdrs_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output fdrs_pkg::fdrs_rsp_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [2:0]          cfg_data
);

	localparam int BYTE_COLS = (COLS_PER_PANEL * MAX_PANELS + 7) / 8;
	localparam int DEPTH     = ROWS * BYTE_COLS;
	localparam int AW        = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int GCOL_W    = $clog2(COLS_PER_PANEL * MAX_PANELS);

	// configuration
	logic       relative_q;
	logic       polarity_q;
	logic [2:0] panels_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relative_q <= 1'b1;
			polarity_q <= 1'b0;
			panels_q   <= 3'd4;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fdrs_pkg::REG_RELATIVE: relative_q <= cfg_data[0];
				fdrs_pkg::REG_POLARITY: polarity_q <= cfg_data[0];
				fdrs_pkg::REG_PANELS:   panels_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan sequencer
	fdrs_pkg::fdrs_scan_cmd_t scan_cmd;
	fdrs_pkg::fdrs_scan_sts_t scan_sts;
	logic [2:0]               scan_row;
	logic [GCOL_W-1:0]        scan_gcol;

	fdrs_scan_seq #(
		.ROWS           (ROWS),
		.COLS_PER_PANEL (COLS_PER_PANEL),
		.MAX_PANELS     (MAX_PANELS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.panels_in_use (panels_q),
		.cmd           (scan_cmd),
		.sts           (scan_sts),
		.row           (scan_row),
		.gcol          (scan_gcol)
	);

	// request beat and read issue
	logic          accept;
	logic          pend_s1;
	fdrs_pkg::fdrs_req_t req_s1;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] rd_addr;
	logic          frame_vld_s1, prev_vld_s1;
	logic          rsp_valid_q;
	fdrs_pkg::fdrs_rsp_t rsp_q;

	assign req_ready = !pend_s1 && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;

	always_comb begin
		if (req.command == fdrs_pkg::CMD_STEP) begin
			rd_addr = AW'(scan_row) * AW'(BYTE_COLS) + AW'(scan_gcol >> 3);
		end else begin
			rd_addr = AW'(req.row_index) * AW'(BYTE_COLS) + AW'(req.byte_col);
		end
	end

	// memories and valid flags
	logic [DEPTH-1:0] frame_vld_q, prev_vld_q;
	logic             frame_we, prev_we;
	logic [7:0]       frame_wdata, prev_wdata;
	logic [7:0]       frame_rdata, prev_rdata;

	fdrs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_frame (
		.clk   (clk),
		.we    (frame_we),
		.waddr (addr_s1),
		.wdata (frame_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (frame_rdata)
	);

	fdrs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_prev (
		.clk   (clk),
		.we    (prev_we),
		.waddr (addr_s1),
		.wdata (prev_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (prev_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			frame_vld_q <= '0;
			prev_vld_q  <= '0;
		end else begin
			pend_s1 <= accept;
			if (frame_we) begin
				frame_vld_q[addr_s1] <= 1'b1;
			end
			if (prev_we) begin
				prev_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1       <= req;
			addr_s1      <= rd_addr;
			frame_vld_s1 <= frame_vld_q[rd_addr];
			prev_vld_s1  <= prev_vld_q[rd_addr];
		end
	end

	// compute and write back
	logic [7:0] frame_cur, prev_cur, mask, bitm;
	logic       in_range, cur, prv, differs, want;
	fdrs_pkg::fdrs_rsp_t rsp_d;

	assign frame_cur = frame_vld_s1 ? frame_rdata : 8'h00;
	assign prev_cur  = prev_vld_s1 ? prev_rdata : 8'h00;
	assign mask      = fdrs_pkg::row_mask(req_s1.row_index[0], polarity_q);
	assign in_range  = (32'(req_s1.byte_col) < BYTE_COLS) && (32'(req_s1.row_index) < ROWS);
	assign bitm      = fdrs_pkg::PIX_MSB >> scan_gcol[2:0];
	assign cur       = |(frame_cur & bitm);
	assign prv       = |(prev_cur & bitm);
	assign differs   = scan_sts.forcing || (cur != prv);
	assign want      = scan_sts.phase ? !cur : cur;

	always_comb begin
		rsp_d       = '0;
		scan_cmd    = '0;
		frame_we    = 1'b0;
		prev_we     = 1'b0;
		frame_wdata = req_s1.byte_data ^ mask;
		prev_wdata  = cur ? (prev_cur | bitm) : (prev_cur & ~bitm);
		if (pend_s1) begin
			unique case (req_s1.command)
				fdrs_pkg::CMD_WRITE, fdrs_pkg::CMD_READ: begin
					rsp_d.rejected = scan_sts.busy || !in_range;
					if (!rsp_d.rejected) begin
						if (req_s1.command == fdrs_pkg::CMD_WRITE) begin
							frame_we = 1'b1;
						end else begin
							rsp_d.read_data = frame_cur ^ mask;
						end
					end
				end
				fdrs_pkg::CMD_REFRESH, fdrs_pkg::CMD_FORCE: begin
					rsp_d.rejected      = scan_sts.busy;
					scan_cmd.start      = !scan_sts.busy;
					scan_cmd.force_scan = (req_s1.command == fdrs_pkg::CMD_FORCE);
				end
				fdrs_pkg::CMD_STEP: begin
					if (scan_sts.busy) begin
						scan_cmd.step = 1'b1;
						prev_we       = scan_sts.phase;
						rsp_d.scan_done = scan_sts.last;
						if (want && (!relative_q || differs)) begin
							rsp_d.pulse_fire = 1'b1;
							rsp_d.pulse_set  = !scan_sts.phase;
							rsp_d.pulse_row  = scan_row;
							rsp_d.pulse_col  = 7'(scan_gcol);
						end
					end
				end
				default: ;
			endcase
		end
		// scanning as it stands after this beat
		rsp_d.scan_busy = scan_cmd.start || (scan_sts.busy && !(scan_cmd.step && scan_sts.last));
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pend_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !accept)
		else $error("request accepted while previous one still computing");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !rsp_valid_q || rsp_ready)
		else $error("result register overwritten before taken");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(frame_we && prev_we))
		else $error("frame and previous frame written by the same beat");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && rsp_d.scan_done) |=> !scan_sts.busy)
		else $error("scan still busy after final step");

	a_quiet_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.pulse_fire) |-> rsp.pulse_col == 7'd0 && !rsp.pulse_set)
		else $error("pulse fields set without a pulse");

endmodule

### rtl/fdrs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module fdrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/fdrs_scan_seq.sv
// refresh scan position counters: row, panel, phase, descending column
// depends on fdrs_pkg
module fdrs_scan_seq #(
	parameter int ROWS           = 8,
	parameter int COLS_PER_PANEL = 32,
	parameter int MAX_PANELS     = 4
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic [2:0]                                  panels_in_use,
	input  fdrs_pkg::fdrs_scan_cmd_t                    cmd,
	output fdrs_pkg::fdrs_scan_sts_t                    sts,
	output logic [2:0]                                  row,
	output logic [$clog2(COLS_PER_PANEL*MAX_PANELS)-1:0] gcol
);

	localparam int COL_W  = $clog2(COLS_PER_PANEL);
	localparam int PNL_W  = MAX_PANELS > 1 ? $clog2(MAX_PANELS) : 1;
	localparam int GCOL_W = $clog2(COLS_PER_PANEL*MAX_PANELS);

	logic [2:0]       row_q;
	logic [PNL_W-1:0] panel_q;
	logic             phase_q;
	logic [COL_W-1:0] col_q;
	logic             busy_q;
	logic             forcing_q;

	logic [3:0] act_panels;
	logic       col_last, panel_last, row_last, last;

	always_comb begin
		priority if (panels_in_use == 3'd0) begin
			act_panels = 4'd1;
		end else if (32'(panels_in_use) > MAX_PANELS) begin
			act_panels = 4'(MAX_PANELS);
		end else begin
			act_panels = {1'b0, panels_in_use};
		end
	end

	assign col_last   = (col_q == '0);
	assign panel_last = (4'(panel_q) + 4'd1) >= act_panels;
	assign row_last   = (row_q == 3'(ROWS - 1));
	assign last       = col_last & phase_q & panel_last & row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			panel_q   <= '0;
			phase_q   <= 1'b0;
			col_q     <= COL_W'(COLS_PER_PANEL - 1);
			busy_q    <= 1'b0;
			forcing_q <= 1'b0;
		end else if (cmd.start) begin
			row_q     <= '0;
			panel_q   <= '0;
			phase_q   <= 1'b0;
			col_q     <= COL_W'(COLS_PER_PANEL - 1);
			busy_q    <= 1'b1;
			forcing_q <= cmd.force_scan;
		end else if (cmd.step) begin
			if (!col_last) begin
				col_q <= col_q - COL_W'(1);
			end else begin
				col_q <= COL_W'(COLS_PER_PANEL - 1);
				if (!phase_q) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					if (!panel_last) begin
						panel_q <= panel_q + PNL_W'(1);
					end else begin
						panel_q <= '0;
						if (!row_last) begin
							row_q <= row_q + 3'd1;
						end else begin
							row_q     <= '0;
							busy_q    <= 1'b0;
							forcing_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	assign sts.busy    = busy_q;
	assign sts.forcing = forcing_q;
	assign sts.phase   = phase_q;
	assign sts.last    = last;
	assign row         = row_q;
	assign gcol        = GCOL_W'(panel_q) * GCOL_W'(COLS_PER_PANEL) + GCOL_W'(col_q);

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < COLS_PER_PANEL)
		else $error("scan column out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < ROWS)
		else $error("scan row out of range");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q && !cmd.step)
		else $error("scan started while busy");

endmodule
